### hdl/double_ended_queue_assert.svh
// Assertion macros used by the deque top-level RTL
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, masked while reset is held
`define DQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held
`define DQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dq_pkg.sv
package dq_pkg;

    // Storage geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int ST_W   = 2;

    // Output tdata: value then count, padded to whole bytes
    localparam int OUT_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

    // Request codes
    typedef enum logic [FUNC_W-1:0] {
        F_PUSH_FRONT = 3'd0,
        F_PUSH_BACK  = 3'd1,
        F_POP_FRONT  = 3'd2,
        F_POP_BACK   = 3'd3,
        F_LENGTH     = 3'd4,
        F_DUMP       = 3'd5,
        F_SORT_DUMP  = 3'd6
    } t_func;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Request to the shared index / compare unit
    typedef struct packed {
        logic [IDX_W-1:0]         base;
        logic [CNT_W-1:0]         offset;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } t_unit_req;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             less;
    } t_unit_rsp;

    // Memory write port
    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         addr;
        logic signed [DATA_W-1:0] data;
    } t_mem_wr;

    // Memory read port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_mem_rd;

endpackage

### hdl/double_ended_queue.sv
// Channel   Dir  tdata (low bit up)                        tuser         tlast
// s (req)   in   item_value[31:0]                          func[2:0]     -
// m (res)   out  result_value[31:0], stored_count[36:32]  status[1:0]   last
//
// One request at a time; o_s_tready is high only between requests.
// Sorted dump copies the ring into scratch, exchange-sorts it there, then sends it out,
// paced by the single read port of each store and the one shared comparator.
// Reset (i_rst_n low, synchronous) empties the deque; stores are not cleared.
// A stalled result holds the sequencer until the beat is taken.
`include "double_ended_queue_assert.svh"

module double_ended_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [dq_pkg::DATA_W-1:0]          i_s_tdata,  // item_value
    input  logic [dq_pkg::FUNC_W-1:0]          i_s_tuser,  // func
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [dq_pkg::OUT_TDATA_W-1:0]     o_m_tdata,  // result_value, stored_count
    output logic [dq_pkg::ST_W-1:0]            o_m_tuser,  // status
    output logic                               o_m_tlast
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_EXEC     = 11'b000_0000_0010,
        S_POP      = 11'b000_0000_0100,
        S_COPY_RD  = 11'b000_0000_1000,
        S_COPY_WR  = 11'b000_0001_0000,
        S_SORT_LD  = 11'b000_0010_0000,
        S_SORT_RD  = 11'b000_0100_0000,
        S_SORT_CMP = 11'b000_1000_0000,
        S_SORT_ST  = 11'b001_0000_0000,
        S_OUT_RD   = 11'b010_0000_0000,
        S_OUT_WR   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [dq_pkg::IDX_W-1:0]         r_front, n_front;
    logic [dq_pkg::CNT_W-1:0]         r_count, n_count;
    logic [dq_pkg::CNT_W-1:0]         r_i, n_i;
    logic [dq_pkg::CNT_W-1:0]         r_j, n_j;
    logic signed [dq_pkg::DATA_W-1:0] r_a, n_a;
    logic                             r_sorted, n_sorted;
    dq_pkg::t_func                    r_func;
    logic signed [dq_pkg::DATA_W-1:0] r_item;

    logic                             r_out_valid;
    logic signed [dq_pkg::DATA_W-1:0] r_out_value;
    logic [dq_pkg::ST_W-1:0]          r_out_status;
    logic [dq_pkg::CNT_W-1:0]         r_out_count;
    logic                             r_out_last;

    logic                             emit;
    logic signed [dq_pkg::DATA_W-1:0] e_value;
    logic [dq_pkg::ST_W-1:0]          e_status;
    logic                             e_last;
    logic                             out_free;
    logic                             s_accept;
    logic                             i_last;
    logic                             j_last;

    dq_pkg::t_unit_req                unit_req;
    dq_pkg::t_unit_rsp                unit_rsp;
    dq_pkg::t_mem_wr                  dq_wr, sc_wr;
    dq_pkg::t_mem_rd                  dq_rd, sc_rd;
    logic signed [dq_pkg::DATA_W-1:0] dq_data, sc_data;

    dq_unit u_unit (
        .i_req (unit_req),
        .o_rsp (unit_rsp)
    );

    dq_mem u_mem (
        .i_clk     (i_clk),
        .i_dq_wr   (dq_wr),
        .i_dq_rd   (dq_rd),
        .o_dq_data (dq_data),
        .i_sc_wr   (sc_wr),
        .i_sc_rd   (sc_rd),
        .o_sc_data (sc_data)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign i_last     = (r_i == r_count - 1'b1);
    assign j_last     = (r_j == r_count - 1'b1);

    // Shared unit operands: ring base and offset, comparator inputs
    always_comb begin
        unit_req.base   = r_front;
        unit_req.offset = r_i;
        unit_req.a      = r_a;
        unit_req.b      = sc_data;
        if (r_state == S_EXEC) begin
            unique case (r_func)
                dq_pkg::F_PUSH_FRONT: unit_req.offset = dq_pkg::CNT_W'(dq_pkg::DEPTH - 1);
                dq_pkg::F_PUSH_BACK:  unit_req.offset = r_count;
                dq_pkg::F_POP_BACK:   unit_req.offset = r_count - 1'b1;
                default:              unit_req.offset = '0;
            endcase
        end else if (r_state == S_POP) begin
            // pop front moves the front on by one
            unit_req.offset = dq_pkg::CNT_W'(1);
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_a      = r_a;
        n_sorted = r_sorted;
        emit     = 1'b0;
        e_value  = '0;
        e_status = dq_pkg::ST_OK;
        e_last   = 1'b1;

        dq_wr      = '0;
        sc_wr      = '0;
        dq_rd.en   = 1'b0;
        dq_rd.addr = unit_rsp.idx;
        sc_rd.en   = 1'b0;
        sc_rd.addr = r_i[dq_pkg::IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    n_i     = '0;
                    unique case (r_func)
                        dq_pkg::F_PUSH_FRONT, dq_pkg::F_PUSH_BACK: begin
                            emit = 1'b1;
                            if (r_count == dq_pkg::CNT_W'(dq_pkg::DEPTH)) begin
                                e_status = dq_pkg::ST_FULL;
                            end else begin
                                dq_wr.en   = 1'b1;
                                dq_wr.addr = unit_rsp.idx;
                                dq_wr.data = r_item;
                                n_count    = r_count + 1'b1;
                                if (r_func == dq_pkg::F_PUSH_FRONT) begin
                                    n_front = unit_rsp.idx;
                                end
                            end
                        end
                        dq_pkg::F_POP_FRONT, dq_pkg::F_POP_BACK: begin
                            if (r_count == '0) begin
                                emit     = 1'b1;
                                e_status = dq_pkg::ST_EMPTY;
                            end else begin
                                dq_rd.en = 1'b1;
                                n_state  = S_POP;
                            end
                        end
                        dq_pkg::F_DUMP, dq_pkg::F_SORT_DUMP: begin
                            if (r_count == '0) begin
                                emit     = 1'b1;
                                e_status = dq_pkg::ST_EMPTY;
                            end else begin
                                n_sorted = (r_func == dq_pkg::F_SORT_DUMP);
                                n_state  = (r_func == dq_pkg::F_SORT_DUMP) ? S_COPY_RD
                                                                          : S_OUT_RD;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_value = dq_data;
                    n_count = r_count - 1'b1;
                    if (r_func == dq_pkg::F_POP_FRONT) begin
                        n_front = unit_rsp.idx;
                    end
                    n_state = S_IDLE;
                end
            end
            // Copy the ring into scratch in logical order
            S_COPY_RD: begin
                dq_rd.en = 1'b1;
                n_state  = S_COPY_WR;
            end
            S_COPY_WR: begin
                sc_wr.en   = 1'b1;
                sc_wr.addr = r_i[dq_pkg::IDX_W-1:0];
                sc_wr.data = dq_data;
                if (i_last) begin
                    n_i     = '0;
                    n_state = S_SORT_LD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_COPY_RD;
                end
            end
            // Exchange sort; r_a carries the live value of scratch[i]
            S_SORT_LD: begin
                sc_rd.en = 1'b1;
                n_j      = '0;
                n_state  = S_SORT_RD;
            end
            S_SORT_RD: begin
                if (r_j == '0) begin
                    n_a = sc_data;
                end
                sc_rd.en   = 1'b1;
                sc_rd.addr = r_j[dq_pkg::IDX_W-1:0];
                n_state    = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if ((r_j != r_i) && unit_rsp.less) begin
                    sc_wr.en   = 1'b1;
                    sc_wr.addr = r_j[dq_pkg::IDX_W-1:0];
                    sc_wr.data = r_a;
                    n_a        = sc_data;
                end
                n_j     = r_j + 1'b1;
                n_state = j_last ? S_SORT_ST : S_SORT_RD;
            end
            S_SORT_ST: begin
                sc_wr.en   = 1'b1;
                sc_wr.addr = r_i[dq_pkg::IDX_W-1:0];
                sc_wr.data = r_a;
                if (i_last) begin
                    n_i     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SORT_LD;
                end
            end
            // Result beats, one entry each
            S_OUT_RD: begin
                dq_rd.en = !r_sorted;
                sc_rd.en = r_sorted;
                n_state  = S_OUT_WR;
            end
            S_OUT_WR: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_value = r_sorted ? sc_data : dq_data;
                    e_last  = i_last;
                    n_i     = r_i + 1'b1;
                    n_state = i_last ? S_IDLE : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_sorted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_count  <= n_count;
            r_i      <= n_i;
            r_j      <= n_j;
            r_sorted <= n_sorted;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: request latch, sort holding value, result beat
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        if (s_accept) begin
            r_func <= dq_pkg::t_func'(i_s_tuser);
            r_item <= i_s_tdata;
        end
        if (emit) begin
            r_out_value  <= e_value;
            r_out_status <= e_status;
            r_out_count  <= n_count;
            r_out_last   <= e_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(dq_pkg::OUT_TDATA_W - dq_pkg::DATA_W - dq_pkg::CNT_W){1'b0}},
                         r_out_count, r_out_value};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

    `DQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= dq_pkg::CNT_W'(dq_pkg::DEPTH), "entry count beyond depth")
    `DQ_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, s_accept, r_state == S_EXEC, "accepted request not executed")
    `DQ_ASSERT_SAME(a_full_status, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == dq_pkg::ST_FULL), r_out_count == dq_pkg::CNT_W'(dq_pkg::DEPTH), "full status with room left")

endmodule

### hdl/dq_unit.sv
module dq_unit (
    input  dq_pkg::t_unit_req i_req,
    output dq_pkg::t_unit_rsp o_rsp
);

    logic [dq_pkg::CNT_W:0] sum;

    // Ring index: base + offset stays below twice the depth for every index used, so one subtract wraps it
    always_comb begin
        sum = {{(dq_pkg::CNT_W + 1 - dq_pkg::IDX_W){1'b0}}, i_req.base}
            + {1'b0, i_req.offset};
        if (sum >= (dq_pkg::CNT_W + 1)'(dq_pkg::DEPTH)) begin
            sum = sum - (dq_pkg::CNT_W + 1)'(dq_pkg::DEPTH);
        end
        o_rsp.idx  = sum[dq_pkg::IDX_W-1:0];
        o_rsp.less = (i_req.a < i_req.b);
    end

endmodule

### hdl/dq_mem.sv
module dq_mem (
    input  logic                            i_clk,
    input  dq_pkg::t_mem_wr                 i_dq_wr,
    input  dq_pkg::t_mem_rd                 i_dq_rd,
    output logic signed [dq_pkg::DATA_W-1:0] o_dq_data,
    input  dq_pkg::t_mem_wr                 i_sc_wr,
    input  dq_pkg::t_mem_rd                 i_sc_rd,
    output logic signed [dq_pkg::DATA_W-1:0] o_sc_data
);

    logic signed [dq_pkg::DATA_W-1:0] r_dq_mem [dq_pkg::DEPTH];
    logic signed [dq_pkg::DATA_W-1:0] r_sc_mem [dq_pkg::DEPTH];

    // Deque ring store
    always_ff @(posedge i_clk) begin
        if (i_dq_wr.en) begin
            r_dq_mem[i_dq_wr.addr] <= i_dq_wr.data;
        end
        if (i_dq_rd.en) begin
            o_dq_data <= r_dq_mem[i_dq_rd.addr];
        end
    end

    // Sort scratch store
    always_ff @(posedge i_clk) begin
        if (i_sc_wr.en) begin
            r_sc_mem[i_sc_wr.addr] <= i_sc_wr.data;
        end
        if (i_sc_rd.en) begin
            o_sc_data <= r_sc_mem[i_sc_rd.addr];
        end
    end

endmodule

### verif/double_ended_queue_tb.sv
module double_ended_queue_tb;
    import dq_pkg::*;

    // Selector with no request behind it; the block answers with a plain ok beat
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

    localparam int N_RANDOM     = 215;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] value;
    } t_dq_request;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic [ST_W-1:0]   status;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_dq_result;

    typedef enum {FILL_HEAVY, DRAIN_HEAVY, BALANCED} t_traffic_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [DATA_W-1:0]      i_s_tdata = '0;   // item_value
    logic [FUNC_W-1:0]      i_s_tuser = '0;   // func
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;        // result_value, stored_count, zero pad
    logic [ST_W-1:0]        o_m_tuser;        // status
    logic                   o_m_tlast;

    double_ended_queue uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Deque mirror and expected beats
    logic [DATA_W-1:0] deque_mirror [DEPTH];
    int                mirror_front = 0;
    int                mirror_count = 0;
    t_dq_result        expected_beats [$];
    t_dq_request       pending_requests [$];

    // Bookkeeping
    int  n_items = 0;
    int  n_accepted = 0;
    int  n_beats = 0;
    int  n_errors = 0;
    int  n_full_drops = 0;
    int  n_empty_hits = 0;
    int  peak_fill = 0;
    int  func_seen [8];
    int  cycles = 0;
    bit  req_taken = 1'b0;
    int  s_gap_left = 0;
    int  s_calm = 0;
    int  m_stall_left = 0;
    int  m_calm = 0;

    function automatic void add_expected(logic [DATA_W-1:0] value, logic [ST_W-1:0] status,
                                         logic last);
        t_dq_result r;
        r.value  = value;
        r.status = status;
        r.count  = CNT_W'(mirror_count);
        r.last   = last;
        expected_beats.push_back(r);
    endfunction

    // Apply one accepted request to the mirror and queue the beats it should produce
    function automatic void apply_request(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] ordered [DEPTH];
        logic [DATA_W-1:0] key;
        int                i, j, pos;
        func_seen[f]++;
        case (f)
            F_PUSH_FRONT, F_PUSH_BACK: begin
                if (mirror_count >= DEPTH) begin
                    add_expected('0, ST_FULL, 1'b1);
                end else begin
                    if (f == F_PUSH_FRONT) begin
                        mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
                        deque_mirror[mirror_front] = v;
                    end else begin
                        deque_mirror[(mirror_front + mirror_count) % DEPTH] = v;
                    end
                    mirror_count++;
                    if (mirror_count > peak_fill)
                        peak_fill = mirror_count;
                    add_expected('0, ST_OK, 1'b1);
                end
            end
            F_POP_FRONT, F_POP_BACK: begin
                if (mirror_count == 0) begin
                    add_expected('0, ST_EMPTY, 1'b1);
                end else if (f == F_POP_FRONT) begin
                    key = deque_mirror[mirror_front];
                    mirror_front = (mirror_front + 1) % DEPTH;
                    mirror_count--;
                    add_expected(key, ST_OK, 1'b1);
                end else begin
                    key = deque_mirror[(mirror_front + mirror_count - 1) % DEPTH];
                    mirror_count--;
                    add_expected(key, ST_OK, 1'b1);
                end
            end
            F_DUMP, F_SORT_DUMP: begin
                if (mirror_count == 0) begin
                    add_expected('0, ST_EMPTY, 1'b1);
                end else begin
                    for (i = 0; i < mirror_count; i++)
                        ordered[i] = deque_mirror[(mirror_front + i) % DEPTH];
                    // ascending signed order; the stored order is left alone
                    if (f == F_SORT_DUMP) begin
                        for (i = 1; i < mirror_count; i++) begin
                            key = ordered[i];
                            pos = i;
                            for (j = i - 1; j >= 0; j--) begin
                                if ($signed(ordered[j]) > $signed(key)) begin
                                    ordered[j + 1] = ordered[j];
                                    pos = j;
                                end else begin
                                    break;
                                end
                            end
                            ordered[pos] = key;
                        end
                    end
                    for (i = 0; i < mirror_count; i++)
                        add_expected(ordered[i], ST_OK, i == mirror_count - 1);
                end
            end
            default: begin
                add_expected('0, ST_OK, 1'b1);
            end
        endcase
    endfunction

    function automatic void add_request(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v);
        t_dq_request q;
        q.func  = f;
        q.value = v;
        pending_requests.push_back(q);
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int rand_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(15, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Extremes, small values that collide in the sort, and full-range words
    function automatic logic [DATA_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        if (r < 50)
            return DATA_W'($signed($urandom_range(0, 15)) - 8);
        return $urandom();
    endfunction

    // Request driver: one beat held until taken, then a random gap
    always @(negedge i_clk) begin
        t_dq_request req;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (s_gap_left > 0) begin
                s_gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                req = pending_requests.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= req.value;
                i_s_tuser  <= req.func;
                s_gap_left = rand_gap(s_calm);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (m_stall_left > 0) begin
            m_stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                m_stall_left = rand_gap(m_calm);
        end
    end

    // Monitor: take accepted requests into the mirror, check every result beat
    always @(posedge i_clk) begin
        t_dq_result want;
        if (i_rst_n) begin
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("%0t: timeout after %0d cycles, %0d of %0d requests taken",
                         $time, cycles, n_accepted, n_items);
                $display("Regression FAIL");
                $finish;
            end else begin
                if (i_s_tvalid && o_s_tready) begin
                    apply_request(i_s_tuser, i_s_tdata);
                    req_taken = 1'b1;
                    n_accepted++;
                end
                if (o_m_tvalid && i_m_tready) begin
                    n_beats++;
                    if (expected_beats.size() == 0) begin
                        n_errors++;
                        $display("%0t: unexpected beat, expected none, actual value %h status %0d count %0d",
                                 $time, o_m_tdata[DATA_W-1:0], o_m_tuser,
                                 o_m_tdata[DATA_W+CNT_W-1:DATA_W]);
                    end else begin
                        want = expected_beats.pop_front();
                        if (o_m_tuser == ST_FULL)
                            n_full_drops++;
                        if (o_m_tuser == ST_EMPTY)
                            n_empty_hits++;
                        if (o_m_tdata[DATA_W-1:0] !== want.value) begin
                            n_errors++;
                            $display("%0t: value mismatch, expected %h actual %h",
                                     $time, want.value, o_m_tdata[DATA_W-1:0]);
                        end
                        if (o_m_tdata[DATA_W+CNT_W-1:DATA_W] !== want.count) begin
                            n_errors++;
                            $display("%0t: count mismatch, expected %0d actual %0d",
                                     $time, want.count, o_m_tdata[DATA_W+CNT_W-1:DATA_W]);
                        end
                        if (o_m_tdata[OUT_TDATA_W-1:DATA_W+CNT_W] !== '0) begin
                            n_errors++;
                            $display("%0t: pad bits mismatch, expected 0 actual %h",
                                     $time, o_m_tdata[OUT_TDATA_W-1:DATA_W+CNT_W]);
                        end
                        if (o_m_tuser !== want.status) begin
                            n_errors++;
                            $display("%0t: status mismatch, expected %0d actual %0d",
                                     $time, want.status, o_m_tuser);
                        end
                        if (o_m_tlast !== want.last) begin
                            n_errors++;
                            $display("%0t: last mismatch, expected %b actual %b",
                                     $time, want.last, o_m_tlast);
                        end
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int              k, r, len, push_pct, pop_pct, n_random;
        logic [FUNC_W-1:0] f;
        t_traffic_mode   mode;

        // Every request but push on an empty deque, including the unused selector
        add_request(F_POP_FRONT, 32'h1234_5678);
        add_request(F_POP_BACK, 32'h0);
        add_request(F_DUMP, 32'h0);
        add_request(F_SORT_DUMP, 32'h0);
        add_request(F_LENGTH, 32'hFFFF_FFFF);
        add_request(FUNC_UNUSED, 32'hFFFF_FFFF);

        // Fill from both ends, extremes first, overflow at both ends, then dump, sort, length and pops
        for (k = 0; k < DEPTH; k++) begin
            case (k)
                0: add_request(F_PUSH_FRONT, 32'h8000_0000);
                1: add_request(F_PUSH_BACK, 32'h7FFF_FFFF);
                2: add_request(F_PUSH_FRONT, 32'h0000_0000);
                3: add_request(F_PUSH_BACK, 32'hFFFF_FFFF);
                default: add_request(k % 2 ? F_PUSH_BACK : F_PUSH_FRONT, rand_word());
            endcase
        end
        add_request(F_PUSH_FRONT, 32'hAAAA_5555);
        add_request(F_PUSH_BACK, 32'h5555_AAAA);
        add_request(F_DUMP, 32'h0);
        add_request(F_SORT_DUMP, 32'h0);
        add_request(F_LENGTH, 32'h0);
        add_request(F_POP_FRONT, 32'h0);
        add_request(F_POP_BACK, 32'h0);

        // Random traffic in episodes that push the deque towards full or empty, or mix pushes and pops more evenly
        n_random = 0;
        while (n_random < N_RANDOM) begin
            mode = t_traffic_mode'($urandom_range(0, 2));
            len  = $urandom_range(8, 30);
            push_pct = (mode == FILL_HEAVY) ? 70 : (mode == DRAIN_HEAVY) ? 25 : 45;
            pop_pct  = (mode == FILL_HEAVY) ? 12 : (mode == DRAIN_HEAVY) ? 55 : 35;
            repeat (len) begin
                r = $urandom_range(0, 99);
                if (r < push_pct) begin
                    f = $urandom_range(0, 1) ? F_PUSH_BACK : F_PUSH_FRONT;
                end else if (r < push_pct + pop_pct) begin
                    f = $urandom_range(0, 1) ? F_POP_BACK : F_POP_FRONT;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        f = F_DUMP;
                    else if (r < 70)
                        f = F_SORT_DUMP;
                    else if (r < 90)
                        f = F_LENGTH;
                    else
                        f = FUNC_UNUSED;
                end
                add_request(f, rand_word());
                n_random++;
            end
        end
        n_items = pending_requests.size();

        // Synchronous reset, released on a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items || expected_beats.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Ran %0d requests (push %0d/%0d, pop %0d/%0d, length %0d, dump %0d, sorted %0d,",
                 n_accepted, func_seen[F_PUSH_FRONT], func_seen[F_PUSH_BACK],
                 func_seen[F_POP_FRONT], func_seen[F_POP_BACK], func_seen[F_LENGTH],
                 func_seen[F_DUMP], func_seen[F_SORT_DUMP]);
        $display("unused %0d), %0d result beats, %0d full drops, %0d empty hits, peak fill %0d",
                 func_seen[FUNC_UNUSED], n_beats, n_full_drops, n_empty_hits, peak_fill);
        if (n_errors == 0 && expected_beats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d beats outstanding", n_errors, expected_beats.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/dq_pkg.sv
hdl/dq_unit.sv
hdl/dq_mem.sv
hdl/double_ended_queue.sv
verif/double_ended_queue_tb.sv
